>>> src/rgb_to_hsv_convert_assert.svh
// Assertion macros for the checker file.
`ifndef RGB_TO_HSV_CONVERT_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RHC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RHC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rhc_pkg.sv
package rhc_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned FieldW = 15;
  localparam int unsigned NumW = 23;
  localparam int unsigned QuoW = 15;

  localparam int unsigned HueFullTurn = 23040;
  localparam int unsigned HueSectorSpan = 3840;
  localparam int unsigned HueGreenBase = 7680;
  localparam int unsigned HueBlueBase = 15360;
  localparam int unsigned PercentScale = 25600;
  localparam int unsigned PercentUnit = 100;

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  // One divider lane: running remainder, quotient bits so far, divisor.
  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [QuoW-1:0]  quo;
    logic [ChanW-1:0] divisor;
  } lane_t;

  typedef struct packed {
    sector_e           sector;
    logic              neg;
    logic              grey;
    logic              black;
    logic [FieldW-1:0] brightness;
  } side_t;

  typedef struct packed {
    lane_t hue;
    lane_t sat;
    side_t side;
  } work_t;

endpackage

>>> src/rhc_if.sv
interface rhc_rgb_if;
  logic                      valid;
  logic                      ready;
  logic [rhc_pkg::ChanW-1:0] red;
  logic [rhc_pkg::ChanW-1:0] green;
  logic [rhc_pkg::ChanW-1:0] blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [rhc_pkg::FieldW-1:0] hue;
  logic [rhc_pkg::FieldW-1:0] saturation;
  logic [rhc_pkg::FieldW-1:0] brightness;

  modport source(output valid, output hue, output saturation, output brightness, input ready);
  modport sink(input valid, input hue, input saturation, input brightness, output ready);
endinterface

>>> src/rhc_front.sv
module rhc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [rhc_pkg::ChanW-1:0] red_i,
  input  logic [rhc_pkg::ChanW-1:0] green_i,
  input  logic [rhc_pkg::ChanW-1:0] blue_i,
  output logic                      valid_o,
  output rhc_pkg::work_t            data_o
);

  localparam int unsigned SumW = rhc_pkg::FieldW + 1;

  typedef struct packed {
    rhc_pkg::sector_e          sector;
    logic [rhc_pkg::ChanW-1:0] top;
    logic [rhc_pkg::ChanW-1:0] span;
    logic [rhc_pkg::ChanW-1:0] mag;
    logic                      neg;
  } pre_t;

  pre_t           pre_d, pre_q;
  logic           pre_v_q;
  rhc_pkg::work_t work_d, work_q;
  logic           work_v_q;

  // Stage 1: max/min, sector pick, signed channel difference.
  always_comb begin
    logic [rhc_pkg::ChanW-1:0] low;
    logic [rhc_pkg::ChanW:0]   diff;
    pre_d.sector = rhc_pkg::SecRed;
    pre_d.top    = red_i;
    if (green_i > pre_d.top) begin
      pre_d.sector = rhc_pkg::SecGreen;
      pre_d.top    = green_i;
    end
    if (blue_i > pre_d.top) begin
      pre_d.sector = rhc_pkg::SecBlue;
      pre_d.top    = blue_i;
    end
    low = red_i;
    if (green_i < low) low = green_i;
    if (blue_i < low) low = blue_i;
    pre_d.span = pre_d.top - low;
    unique case (pre_d.sector)
      rhc_pkg::SecRed:   diff = {1'b0, green_i} - {1'b0, blue_i};
      rhc_pkg::SecGreen: diff = {1'b0, blue_i} - {1'b0, red_i};
      rhc_pkg::SecBlue:  diff = {1'b0, red_i} - {1'b0, green_i};
      default:           diff = '0;
    endcase
    pre_d.neg = diff[rhc_pkg::ChanW];
    pre_d.mag = pre_d.neg ? rhc_pkg::ChanW'(-diff) : diff[rhc_pkg::ChanW-1:0];
  end

  // Stage 2: numerators by constant scaling; brightness = y + floor(y / 255), y = 100 * max.
  always_comb begin
    logic [rhc_pkg::FieldW-1:0] scaled;
    logic [SumW-1:0]            corr;
    scaled = rhc_pkg::FieldW'(pre_q.top) * rhc_pkg::FieldW'(rhc_pkg::PercentUnit);
    corr   = ({1'b0, scaled} + SumW'(scaled >> rhc_pkg::ChanW) + SumW'(1)) >> rhc_pkg::ChanW;

    work_d.hue.rem     = rhc_pkg::NumW'(pre_q.mag) * rhc_pkg::NumW'(rhc_pkg::HueSectorSpan);
    work_d.hue.quo     = '0;
    work_d.hue.divisor = pre_q.span;
    work_d.sat.rem     = rhc_pkg::NumW'(pre_q.span) * rhc_pkg::NumW'(rhc_pkg::PercentScale);
    work_d.sat.quo     = '0;
    work_d.sat.divisor = pre_q.top;

    work_d.side.sector     = pre_q.sector;
    work_d.side.neg        = pre_q.neg;
    work_d.side.grey       = (pre_q.span == '0);
    work_d.side.black      = (pre_q.top == '0);
    work_d.side.brightness = scaled + rhc_pkg::FieldW'(corr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q  <= 1'b0;
      work_v_q <= 1'b0;
    end else if (en_i) begin
      pre_v_q  <= valid_i;
      work_v_q <= pre_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q  <= pre_d;
      work_q <= work_d;
    end
  end

  assign valid_o = work_v_q;
  assign data_o  = work_q;

endmodule

>>> src/rhc_div.sv
module rhc_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  rhc_pkg::work_t data_i,
  output logic           valid_o,
  output rhc_pkg::work_t data_o
);

  localparam int unsigned Depth = rhc_pkg::QuoW;

  // Restoring step on one lane: try divisor shifted to quotient bit sh.
  function automatic rhc_pkg::lane_t lane_step(rhc_pkg::lane_t l, int unsigned sh);
    logic [rhc_pkg::NumW-1:0] dsh;
    rhc_pkg::lane_t           r;
    r   = l;
    dsh = rhc_pkg::NumW'(l.divisor) << sh;
    if (l.rem >= dsh) begin
      r.rem = l.rem - dsh;
      r.quo = l.quo | (rhc_pkg::QuoW'(1) << sh);
    end
    return r;
  endfunction

  rhc_pkg::work_t   st_q [Depth];
  logic [Depth-1:0] v_q;

  for (genvar k = 0; k < Depth; k++) begin : g_stage
    rhc_pkg::work_t cur;
    rhc_pkg::work_t nxt;
    logic           cur_v;

    if (k == 0) begin : g_head
      assign cur   = data_i;
      assign cur_v = valid_i;
    end else begin : g_body
      assign cur   = st_q[k-1];
      assign cur_v = v_q[k-1];
    end

    always_comb begin
      nxt     = cur;
      nxt.hue = lane_step(cur.hue, Depth - 1 - k);
      nxt.sat = lane_step(cur.sat, Depth - 1 - k);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign valid_o = v_q[Depth-1];
  assign data_o  = st_q[Depth-1];

endmodule

>>> src/rhc_out.sv
module rhc_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  rhc_pkg::work_t data_i,
  output logic           en_o,
  rhc_hsv_if.source      hsv_o
);

  typedef struct packed {
    logic [rhc_pkg::FieldW-1:0] hue;
    logic [rhc_pkg::FieldW-1:0] saturation;
    logic [rhc_pkg::FieldW-1:0] brightness;
  } res_t;

  res_t res_d, out_q, skid_q;
  logic out_v_q, skid_v_q;

  // Negative offsets take the ceiling so base minus it equals the floor of the sum.
  always_comb begin
    logic [rhc_pkg::QuoW-1:0] ofs;
    ofs = data_i.hue.quo
        + rhc_pkg::QuoW'(data_i.side.neg && (data_i.hue.rem != '0));
    unique case (data_i.side.sector)
      rhc_pkg::SecRed:
        res_d.hue = data_i.side.neg ? rhc_pkg::FieldW'(rhc_pkg::HueFullTurn) - ofs : ofs;
      rhc_pkg::SecGreen:
        res_d.hue = data_i.side.neg ? rhc_pkg::FieldW'(rhc_pkg::HueGreenBase) - ofs
                                    : rhc_pkg::FieldW'(rhc_pkg::HueGreenBase) + ofs;
      rhc_pkg::SecBlue:
        res_d.hue = data_i.side.neg ? rhc_pkg::FieldW'(rhc_pkg::HueBlueBase) - ofs
                                    : rhc_pkg::FieldW'(rhc_pkg::HueBlueBase) + ofs;
      default:
        res_d.hue = '0;
    endcase
    if (data_i.side.grey) res_d.hue = '0;
    res_d.saturation = data_i.side.black ? '0 : data_i.sat.quo;
    res_d.brightness = data_i.side.brightness;
  end

  // Pipeline advances only while the skid slot is free.
  assign en_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (hsv_o.ready) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || hsv_o.ready) begin
      out_v_q <= valid_i;
    end else if (valid_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (hsv_o.ready) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || hsv_o.ready) begin
      out_q <= res_d;
    end else begin
      skid_q <= res_d;
    end
  end

  assign hsv_o.valid      = out_v_q;
  assign hsv_o.hue        = out_q.hue;
  assign hsv_o.saturation = out_q.saturation;
  assign hsv_o.brightness = out_q.brightness;

endmodule

>>> src/rgb_to_hsv_convert.sv
// RGB to HSV pixel converter, fixed point hue/saturation/brightness.
// An accepted pixel beat passes the front stages, the divider and the output register on its way to hsv_o.
// Throughput: one beat per cycle while the output buffer is not full; the 15-stage restoring divider sets the depth.
// A two-entry output buffer takes one more beat while one result waits, then stalls the pipeline.
// Reset (rst_ni low, asynchronous) empties the pipeline and the output buffer.
module rgb_to_hsv_convert (
  input  logic       clk_i,
  input  logic       rst_ni,
  rhc_rgb_if.sink    pixel_i,
  rhc_hsv_if.source  hsv_o
);

  // Global advance: every front and divider register moves together when the skid
  // slot is empty, so a stall freezes the whole chain and nothing is dropped.
  logic           adv;
  logic           front_v;
  rhc_pkg::work_t front_data;
  logic           div_v;
  rhc_pkg::work_t div_data;

  assign pixel_i.ready = adv;

  // Two stages: channel ordering, then constant scaling of numerators.
  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pixel_i.valid),
    .red_i   (pixel_i.red),
    .green_i (pixel_i.green),
    .blue_i  (pixel_i.blue),
    .valid_o (front_v),
    .data_o  (front_data)
  );

  // Fifteen stages, one quotient bit each, hue and saturation lanes side by side.
  rhc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (front_v),
    .data_i  (front_data),
    .valid_o (div_v),
    .data_o  (div_data)
  );

  // Hue assembly from sector base and quotient, then output register plus skid.
  rhc_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_v),
    .data_i  (div_data),
    .en_o    (adv),
    .hsv_o   (hsv_o)
  );

endmodule

>>> src/rhc_checker.sv
`include "rgb_to_hsv_convert_assert.svh"

module rhc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [rhc_pkg::FieldW-1:0] hue_i,
  input logic [rhc_pkg::FieldW-1:0] saturation_i,
  input logic [rhc_pkg::FieldW-1:0] brightness_i
);

  `RHC_ASSERT_NEXT(a_valid_hold, out_valid_i && !out_ready_i, out_valid_i, "result beat dropped while stalled")
  `RHC_ASSERT_NEXT(a_data_hold, out_valid_i && !out_ready_i, $stable(hue_i) && $stable(saturation_i) && $stable(brightness_i), "result beat changed while stalled")
  `RHC_ASSERT_NOW(a_hue_range, out_valid_i, hue_i < rhc_pkg::FieldW'(rhc_pkg::HueFullTurn), "hue out of range")
  `RHC_ASSERT_NOW(a_grey_hue, out_valid_i && (saturation_i == '0), hue_i == '0, "grey pixel with nonzero hue")
  `RHC_ASSERT_NOW(a_black_sat, out_valid_i && (brightness_i == '0), saturation_i == '0, "black pixel with nonzero saturation")

endmodule

bind rgb_to_hsv_convert rhc_checker u_rhc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (hsv_o.valid),
  .out_ready_i  (hsv_o.ready),
  .hue_i        (hsv_o.hue),
  .saturation_i (hsv_o.saturation),
  .brightness_i (hsv_o.brightness)
);

>>> bench/tb.sv
`timescale 1ns / 100ps

// Stimulus and scoreboard for rgb_to_hsv_convert.
// Every pixel beat accepted on pixel_i is turned into an expected HSV triple by an
// integer model kept in this file. Every beat leaving on hsv_o is checked, field by
// field, against the oldest expected triple.
module tb;

  // Brightness divides by the full scale of one channel.
  localparam int ChannelFull = 255;
  // Abort after this many cycles in a row with no beat on either side. The longest
  // correct quiet stretch comes from the deliberate output hold (StallCycles), so
  // this leaves a wide margin.
  localparam int QuietLimit = 2000;
  localparam int StallCycles = 200;
  localparam int DrainCycles = 30;
  localparam int MaxPrinted = 40;

  typedef struct packed {
    logic [rhc_pkg::ChanW-1:0] red;
    logic [rhc_pkg::ChanW-1:0] green;
    logic [rhc_pkg::ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [rhc_pkg::FieldW-1:0] hue;
    logic [rhc_pkg::FieldW-1:0] saturation;
    logic [rhc_pkg::FieldW-1:0] brightness;
  } hsv_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rhc_rgb_if pixel_if ();
  rhc_hsv_if hsv_if ();

  rgb_to_hsv_convert dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pixel_i(pixel_if.sink),
    .hsv_o  (hsv_if.source)
  );

  hsv_t expected_hsv_q[$];
  int   error_count = 0;
  int   quiet_cycles = 0;
  // Idle controls set by the test tasks and read by the sender and the receiver.
  bit   tx_idle_on = 1'b0;
  bit   rx_idle_on = 1'b0;
  int   rx_hold_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Convert one pixel the way the block must: integer arithmetic throughout,
  // with every division taken as the floor of non-negative operands.
  function automatic hsv_t hsv_of_pixel(rgb_t px);
    int               r;
    int               g;
    int               b;
    int               top;
    int               low;
    int               span;
    int               num;
    rhc_pkg::sector_e sector;
    hsv_t             res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    low = r;
    if (g < low) low = g;
    if (b < low) low = b;
    span = top - low;
    // On a tie for the maximum, red wins over green and green over blue.
    if (r == top) begin
      sector = rhc_pkg::SecRed;
    end else if (g == top) begin
      sector = rhc_pkg::SecGreen;
    end else begin
      sector = rhc_pkg::SecBlue;
    end
    case (sector)
      rhc_pkg::SecRed: begin
        num = int'(rhc_pkg::HueSectorSpan) * (g - b) + int'(rhc_pkg::HueFullTurn) * span;
      end
      rhc_pkg::SecGreen: begin
        num = int'(rhc_pkg::HueSectorSpan) * (b - r) + int'(rhc_pkg::HueGreenBase) * span;
      end
      default: begin
        num = int'(rhc_pkg::HueSectorSpan) * (r - g) + int'(rhc_pkg::HueBlueBase) * span;
      end
    endcase
    // A grey pixel has no hue; a black pixel has no saturation.
    if (span == 0) begin
      res.hue = '0;
    end else begin
      res.hue = rhc_pkg::FieldW'((num / span) % int'(rhc_pkg::HueFullTurn));
    end
    if (top == 0) begin
      res.saturation = '0;
    end else begin
      res.saturation = rhc_pkg::FieldW'((span * int'(rhc_pkg::PercentScale)) / top);
    end
    res.brightness = rhc_pkg::FieldW'((top * int'(rhc_pkg::PercentScale)) / ChannelFull);
    return res;
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int idle_gap(bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [rhc_pkg::ChanW-1:0] near_channel(int base);
    int v;
    v = base + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > ChannelFull) v = ChannelFull;
    return rhc_pkg::ChanW'(v);
  endfunction

  // Random pixels favouring the corners: equal channel pairs (a tie for the maximum
  // if the pair is on top), near-grey pixels (tiny hue divisors), very dark pixels.
  function automatic rgb_t random_pixel();
    int   kind;
    int   base;
    rgb_t px;
    kind = $urandom_range(0, 99);
    px.red = rhc_pkg::ChanW'($urandom_range(0, 255));
    px.green = rhc_pkg::ChanW'($urandom_range(0, 255));
    px.blue = rhc_pkg::ChanW'($urandom_range(0, 255));
    if (kind < 45) begin
      return px;
    end else if (kind < 65) begin
      case ($urandom_range(0, 2))
        0: px.green = px.red;
        1: px.blue = px.red;
        default: px.blue = px.green;
      endcase
    end else if (kind < 85) begin
      base = $urandom_range(0, 255);
      px.red = near_channel(base);
      px.green = near_channel(base);
      px.blue = near_channel(base);
    end else begin
      px.red = rhc_pkg::ChanW'($urandom_range(0, 3));
      px.green = rhc_pkg::ChanW'($urandom_range(0, 3));
      px.blue = rhc_pkg::ChanW'($urandom_range(0, 3));
    end
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string field, input logic [rhc_pkg::FieldW-1:0] got,
                               input logic [rhc_pkg::FieldW-1:0] want, input rgb_t px);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d (rgb %0d,%0d,%0d)",
                                field, got, want, px.red, px.green, px.blue));
    end
  endtask

  // Offer one pixel beat, after a random gap if idling is on, and hold it until
  // the block takes it. Valid stays high on return so back-to-back beats need
  // only one assignment per edge.
  task automatic send_pixel(input rgb_t px);
    int gap;
    gap = idle_gap(tx_idle_on);
    if (gap > 0) begin
      pixel_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pixel_if.valid <= 1'b1;
    pixel_if.red <= px.red;
    pixel_if.green <= px.green;
    pixel_if.blue <= px.blue;
    do @(posedge clk_i); while (!pixel_if.ready);
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    send_pixel('{red: rhc_pkg::ChanW'(r), green: rhc_pkg::ChanW'(g),
                 blue: rhc_pkg::ChanW'(b)});
  endtask

  // Drop valid and wait for every expected result to come back.
  task automatic drain_results();
    pixel_if.valid <= 1'b0;
    while (expected_hsv_q.size() != 0) @(posedge clk_i);
  endtask

  // Input and output monitor. Both sides are driven by nonblocking assignments,
  // so at the edge every signal still shows the value it held through the cycle.
  // The sample buffer keeps the pixel for the mismatch message.
  rgb_t pixel_hist_q[$];

  always @(posedge clk_i) begin
    hsv_t want;
    rgb_t px;
    if (rst_ni) begin
      if (hsv_if.valid && hsv_if.ready) begin
        if (expected_hsv_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result hue %0d sat %0d bright %0d",
                                    hsv_if.hue, hsv_if.saturation, hsv_if.brightness));
        end else begin
          want = expected_hsv_q.pop_front();
          px = pixel_hist_q.pop_front();
          compare_field("hue", hsv_if.hue, want.hue, px);
          compare_field("saturation", hsv_if.saturation, want.saturation, px);
          compare_field("brightness", hsv_if.brightness, want.brightness, px);
        end
      end
      if (pixel_if.valid && pixel_if.ready) begin
        px = '{red: pixel_if.red, green: pixel_if.green, blue: pixel_if.blue};
        expected_hsv_q.push_back(hsv_of_pixel(px));
        pixel_hist_q.push_back(px);
      end
    end
  end

  // Receiver: random ready gaps, or a long hold when a test asks for one.
  initial begin
    int gap;
    hsv_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        hsv_if.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else begin
        gap = idle_gap(rx_idle_on);
        if (gap > 0) begin
          hsv_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        hsv_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((pixel_if.valid && pixel_if.ready) || (hsv_if.valid && hsv_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d quiet cycles", QuietLimit);
      $display("[rgb_to_hsv_convert] ERROR");
      $finish;
    end
  end

  // Extremes and special cases, streamed without idling.
  task automatic test_corner_pixels();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_rgb(0, 0, 0);        // black: no hue, no saturation
    send_rgb(255, 255, 255);  // white
    send_rgb(128, 128, 128);  // mid grey
    send_rgb(1, 1, 1);        // darkest grey
    send_rgb(255, 0, 0);      // primaries
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(255, 255, 0);    // red ties green: red sector
    send_rgb(255, 0, 255);    // red ties blue: red sector
    send_rgb(0, 255, 255);    // green ties blue: green sector
    send_rgb(255, 0, 1);      // red sector with blue above green: hue wraps near 360
    send_rgb(255, 1, 0);
    send_rgb(1, 0, 0);        // smallest nonzero channel in each sector
    send_rgb(0, 1, 0);
    send_rgb(0, 0, 1);
    send_rgb(255, 254, 0);
    send_rgb(254, 255, 0);
    send_rgb(0, 254, 255);
    send_rgb(1, 0, 255);
    send_rgb(255, 255, 254);  // one-step span at full scale
    send_rgb(8'h55, 8'hAA, 8'h00);
    send_rgb(8'hAA, 8'h55, 8'hFF);
    drain_results();
  endtask

  // Bulk random pixels with gaps on both sides.
  task automatic test_random_pixels(input int count);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (count) send_pixel(random_pixel());
    drain_results();
  endtask

  // Full rate: one pixel per cycle with the output always ready.
  task automatic test_full_rate(input int count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (count) send_pixel(random_pixel());
    drain_results();
  endtask

  // Hold the output off long enough for the pipeline and output buffer to fill,
  // while the sender keeps offering; the block must stall its input and lose nothing.
  task automatic test_output_stall(input int count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_cycles = StallCycles;
    repeat (count) send_pixel(random_pixel());
    drain_results();
  endtask

  initial begin
    rst_ni <= 1'b0;
    pixel_if.valid <= 1'b0;
    pixel_if.red <= '0;
    pixel_if.green <= '0;
    pixel_if.blue <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_random_pixels(390);
    test_full_rate(80);
    test_output_stall(60);

    // Let any stray result show up before the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && expected_hsv_q.size() == 0) begin
      $display("[rgb_to_hsv_convert] OK");
    end else begin
      $display("[rgb_to_hsv_convert] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/rhc_pkg.sv
src/rhc_if.sv
src/rhc_front.sv
src/rhc_div.sv
src/rhc_out.sv
src/rgb_to_hsv_convert.sv
src/rhc_checker.sv
bench/tb.sv
